// ===== src/lbom_pkg.sv =====
// shared constants, types and tables for the laser beam object mask
// no dependencies; every other file imports this package
package lbom_pkg;

  localparam int MAX_OBJECTS  = 16;
  localparam int MAX_BEAMS    = 2048;
  localparam int CORDIC_STEPS = 16;

  localparam int OBJ_AW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int CNT_W  = $clog2(MAX_OBJECTS + 1);
  localparam int STEP_W = 5;

  localparam int OP_W       = 2;
  localparam int COORD_W    = 16;
  localparam int IDX_W      = 11;
  localparam int RANGE_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int LIMIT_W    = 12;
  localparam int ANGLE_W    = 20;

  // angle datapath widths
  localparam int PROD_W = 27;  // angle_step * beam_index
  localparam int MW     = 28;  // reduced angle, unsigned
  localparam int WW     = 20;  // wrapped angle, q16 signed
  localparam int ZW     = 35;  // cordic angle, q30 signed
  localparam int XGW    = 32;  // gain-scaled range
  localparam int XW     = 36;  // cordic x and y, q16 signed
  localparam int EW     = 28;  // end point, q8 signed
  localparam int DW     = 29;  // offset to object
  localparam int SQW    = 2 * DW;
  localparam int R2W    = 48;

  localparam int RED_STEPS = 10;

  localparam longint TWO_PI_Q16  = 411775;
  localparam longint PI_Q16      = 205887;
  localparam longint PI_Q30      = 64'd3373259426;
  localparam longint HALF_PI_Q30 = 1686629713;
  localparam longint GAIN_Q30    = 652032874;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_BEAM  = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS = 3'd0,
    REG_START  = 3'd1,
    REG_STEP   = 3'd2,
    REG_MAXR   = 3'd3,
    REG_LIMIT  = 3'd4
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_ADD, ST_RED, ST_WRAP, ST_FOLD, ST_ROT, ST_ROUND,
    ST_RD, ST_DIFF, ST_SQ, ST_CMP, ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    DP_NOP, DP_CLR, DP_ADD, DP_LOAD, DP_MUL, DP_ANG, DP_RED, DP_WRAP,
    DP_FOLD, DP_ROT, DP_ROUND, DP_RD, DP_DIFF, DP_SQ, DP_CMP, DP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e            op;
    logic [STEP_W-1:0] step;
    logic [OBJ_AW-1:0] obj;
  } cmd_t;

  typedef struct packed {
    logic             pass;      // beam bypasses the mask
    logic             hit;       // current object covers the end point
    logic             last_obj;  // current object is the last stored one
    logic             out_busy;  // result register still held by receiver
    logic [CNT_W-1:0] count;
  } stat_t;

  // atan(2^-i) in q30
  function automatic logic [31:0] atan_q30(input logic [STEP_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/lbom_if.sv =====
// valid/ready channel interfaces for items in and results out
// depends on lbom_pkg for field widths
interface lbom_in_if;
  import lbom_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           op;
  logic signed [COORD_W-1:0] obj_x;
  logic signed [COORD_W-1:0] obj_y;
  logic [IDX_W-1:0]          beam_index;
  logic [RANGE_W-1:0]        beam_range;

  modport source (output valid, op, obj_x, obj_y, beam_index, beam_range, input ready);
  modport sink (input valid, op, obj_x, obj_y, beam_index, beam_range, output ready);
endinterface

interface lbom_out_if;
  import lbom_pkg::*;
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   out_index;
  logic [RANGE_W-1:0] out_range;
  logic               masked;

  modport source (output valid, out_index, out_range, masked, input ready);
  modport sink (input valid, out_index, out_range, masked, output ready);
endinterface

// ===== src/lbom_ctrl.sv =====
// sequencer for the mask: steps the datapath through angle reduction,
// cordic rotation and the object walk; depends on lbom_pkg
module lbom_ctrl
  import lbom_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [OP_W-1:0] in_op_i,
  input  stat_t           stat_i,
  output logic            in_ready_o,
  output cmd_t            cmd_o
);

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [OBJ_AW-1:0] obj_q, obj_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      obj_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      obj_q   <= obj_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    obj_d       = obj_q;
    in_ready_o  = 1'b0;
    cmd_o.op    = DP_NOP;
    cmd_o.step  = step_q;
    cmd_o.obj   = obj_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_op_i)
            OP_CLEAR: cmd_o.op = DP_CLR;
            OP_ADD:   cmd_o.op = DP_ADD;
            OP_BEAM: begin
              cmd_o.op = DP_LOAD;
              state_d  = ST_MUL;
            end
            default: cmd_o.op = DP_NOP;
          endcase
        end
      end
      ST_MUL: begin
        cmd_o.op = DP_MUL;
        state_d  = stat_i.pass ? ST_DONE : ST_ADD;
      end
      ST_ADD: begin
        cmd_o.op = DP_ANG;
        step_d   = '0;
        state_d  = ST_RED;
      end
      ST_RED: begin
        cmd_o.op = DP_RED;
        if (step_q == STEP_W'(RED_STEPS - 1)) begin
          step_d  = '0;
          state_d = ST_WRAP;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_WRAP: begin
        cmd_o.op = DP_WRAP;
        state_d  = ST_FOLD;
      end
      ST_FOLD: begin
        cmd_o.op = DP_FOLD;
        step_d   = '0;
        state_d  = ST_ROT;
      end
      ST_ROT: begin
        cmd_o.op = DP_ROT;
        if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
          step_d  = '0;
          state_d = ST_ROUND;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_ROUND: begin
        cmd_o.op = DP_ROUND;
        obj_d    = '0;
        state_d  = ST_RD;
      end
      ST_RD: begin
        cmd_o.op = DP_RD;
        state_d  = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.op = DP_DIFF;
        state_d  = ST_SQ;
      end
      ST_SQ: begin
        cmd_o.op = DP_SQ;
        state_d  = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.op = DP_CMP;
        if (stat_i.hit || stat_i.last_obj) begin
          state_d = ST_DONE;
        end else begin
          obj_d   = obj_q + 1'b1;
          state_d = ST_RD;
        end
      end
      ST_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = DP_OUT;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== src/lbom_dp.sv =====
// datapath: config registers, object table, angle reduction, cordic,
// distance test and result register; depends on lbom_pkg
module lbom_dp
  import lbom_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  input  logic signed [COORD_W-1:0] obj_x_i,
  input  logic signed [COORD_W-1:0] obj_y_i,
  input  logic [IDX_W-1:0]          beam_index_i,
  input  logic [RANGE_W-1:0]        beam_range_i,
  input  cmd_t                      cmd_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [IDX_W-1:0]          out_index_o,
  output logic [RANGE_W-1:0]        out_range_o,
  output logic                      masked_o,
  output stat_t                     stat_o
);

  localparam logic signed [ZW-1:0] HALF_PI = ZW'(HALF_PI_Q30);
  localparam logic signed [ZW-1:0] PI_Z    = ZW'(PI_Q30);

  // configuration
  logic [15:0]               radius_q;
  logic signed [ANGLE_W-1:0] start_q;
  logic [15:0]               astep_q;
  logic [RANGE_W-1:0]        maxr_q;
  logic [LIMIT_W-1:0]        limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 16'd500;
      start_q  <= '0;
      astep_q  <= 16'd1;
      maxr_q   <= 16'hFFFF;
      limit_q  <= LIMIT_W'(2048);
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_RADIUS: radius_q <= cfg_data_i[15:0];
        REG_START:  start_q  <= $signed(cfg_data_i[ANGLE_W-1:0]);
        REG_STEP:   astep_q  <= cfg_data_i[15:0];
        REG_MAXR:   maxr_q   <= cfg_data_i[RANGE_W-1:0];
        REG_LIMIT:  limit_q  <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // object table and fill count
  logic [2*COORD_W-1:0] obj_mem [MAX_OBJECTS];
  logic [2*COORD_W-1:0] obj_rd_q;
  logic [CNT_W-1:0]     count_q;
  logic                 add_ok;

  assign add_ok = (count_q < CNT_W'(MAX_OBJECTS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.op == DP_CLR) begin
      count_q <= '0;
    end else if (cmd_i.op == DP_ADD && add_ok) begin
      count_q <= count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_ADD && add_ok) begin
      obj_mem[count_q[OBJ_AW-1:0]] <= {obj_x_i, obj_y_i};
    end
    if (cmd_i.op == DP_RD) begin
      obj_rd_q <= obj_mem[cmd_i.obj];
    end
  end

  // beam arithmetic
  logic [IDX_W-1:0]         idx_q;
  logic [RANGE_W-1:0]       range_q;
  logic [PROD_W-1:0]        prod_q;
  logic [XGW-1:0]           xg_q;
  logic [MW-1:0]            m_q;
  logic signed [WW-1:0]     w_q;
  logic signed [ZW-1:0]     z_q;
  logic signed [XW-1:0]     x_q, y_q;
  logic                     neg_q;
  logic signed [EW-1:0]     ex_q, ey_q;
  logic signed [DW-1:0]     dx_q, dy_q;
  logic signed [SQW-1:0]    sqx_q, sqy_q;
  logic [R2W-1:0]           r2_q;
  logic                     hit_q;

  logic [45:0]              gain_prod;
  logic signed [MW:0]       ang;
  logic [3:0]               red_sh;
  logic [MW-1:0]            red_sub;
  logic signed [MW:0]       wrap_t;
  logic signed [ZW-1:0]     z0;
  logic signed [XW-1:0]     xs, ys;
  logic signed [ZW-1:0]     at;
  logic signed [XW-1:0]     xv, yv, xr, yr;
  logic signed [DW-1:0]     ox, oy;
  logic signed [SQW:0]      dsum;
  logic [23:0]              r_q8;

  assign gain_prod = 46'(range_q) * 46'(GAIN_Q30);
  assign ang       = (MW+1)'(start_q) + $signed({2'b0, prod_q});
  assign red_sh    = 4'(RED_STEPS - 1) - cmd_i.step[3:0];
  assign red_sub   = MW'(TWO_PI_Q16) << red_sh;
  assign wrap_t    = $signed({1'b0, m_q}) - (MW+1)'(TWO_PI_Q16);
  assign z0        = ZW'(w_q) <<< 14;
  assign xs        = x_q >>> cmd_i.step;
  assign ys        = y_q >>> cmd_i.step;
  assign at        = $signed({3'b0, atan_q30(cmd_i.step)});
  assign xv        = neg_q ? -x_q : x_q;
  assign yv        = neg_q ? -y_q : y_q;
  assign xr        = (xv + XW'(128)) >>> 8;
  assign yr        = (yv + XW'(128)) >>> 8;
  assign ox        = DW'($signed(obj_rd_q[2*COORD_W-1:COORD_W])) <<< 8;
  assign oy        = DW'($signed(obj_rd_q[COORD_W-1:0])) <<< 8;
  assign dsum      = (SQW+1)'(sqx_q) + (SQW+1)'(sqy_q);
  assign r_q8      = {radius_q, 8'b0};

  always_ff @(posedge clk_i) begin
    r2_q <= R2W'(r_q8) * R2W'(r_q8);
    case (cmd_i.op)
      DP_LOAD: begin
        idx_q   <= beam_index_i;
        range_q <= beam_range_i;
      end
      DP_MUL: begin
        prod_q <= PROD_W'(astep_q) * PROD_W'(idx_q);
        xg_q   <= gain_prod[45:14];
      end
      DP_ANG: m_q <= ang[MW] ? MW'(ang + (MW+1)'(TWO_PI_Q16)) : ang[MW-1:0];
      DP_RED: begin
        if (m_q >= red_sub) m_q <= m_q - red_sub;
      end
      DP_WRAP: w_q <= (m_q > MW'(PI_Q16)) ? wrap_t[WW-1:0] : $signed(m_q[WW-1:0]);
      DP_FOLD: begin
        x_q <= $signed({{(XW-XGW){1'b0}}, xg_q});
        y_q <= '0;
        if (z0 > HALF_PI) begin
          z_q   <= z0 - PI_Z;
          neg_q <= 1'b1;
        end else if (z0 < -HALF_PI) begin
          z_q   <= z0 + PI_Z;
          neg_q <= 1'b1;
        end else begin
          z_q   <= z0;
          neg_q <= 1'b0;
        end
      end
      DP_ROT: begin
        if (!z_q[ZW-1]) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + at;
        end
      end
      DP_ROUND: begin
        ex_q <= xr[EW-1:0];
        ey_q <= yr[EW-1:0];
      end
      DP_DIFF: begin
        dx_q <= DW'(ex_q) - ox;
        dy_q <= DW'(ey_q) - oy;
      end
      DP_SQ: begin
        sqx_q <= dx_q * dx_q;
        sqy_q <= dy_q * dy_q;
      end
      default: ;
    endcase
  end

  assign stat_o.hit      = (dsum < $signed({{(SQW+1-R2W){1'b0}}, r2_q}));
  assign stat_o.last_obj = ((CNT_W'(cmd_i.obj) + 1'b1) == count_q);
  assign stat_o.count    = count_q;
  assign stat_o.pass     = (count_q == '0) || ({1'b0, idx_q} >= limit_q)
                         || (32'(idx_q) >= 32'(MAX_BEAMS));
  assign stat_o.out_busy = out_valid_o && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (cmd_i.op == DP_LOAD) begin
      hit_q <= 1'b0;
    end else if (cmd_i.op == DP_CMP && stat_o.hit) begin
      hit_q <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.op == DP_OUT) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_OUT) begin
      out_index_o <= idx_q;
      out_range_o <= hit_q ? maxr_q : range_q;
      masked_o    <= hit_q;
    end
  end

endmodule

// ===== src/laser_beam_object_mask.sv =====
// Laser beam object mask, top level.
// Input channel in_i carries one item: op clear empties the object table,
// op add stores obj_x/obj_y (dropped once 16 objects are held), op beam
// presents beam_index/beam_range. Clear and add give no result. Every
// beam gives one result on out_o: the index, the range (or max_range
// when the end point lies strictly inside the mask radius of a stored
// object) and the masked flag.
// A beam that bypasses (empty table or index at or above beam_limit) skips
// the angle and object work. Otherwise it passes through the multiply,
// angle reduction, wrap and fold, the cordic iterations and rounding, then
// for each object in turn the table read, offsets, squares and compare, up
// to and including the first hit or the last stored object.
// One item is worked on at a time; the next is accepted as soon as the
// result is parked in the output register, even if the receiver stalls.
// Results wait there while out_o.ready is low; a second beam then waits
// for that register to empty.
// Reset empties the table and loads the register defaults; config writes
// on cfg_we_i/cfg_idx_i/cfg_data_i must only be issued while idle.
module laser_beam_object_mask
  import lbom_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  lbom_in_if.sink               in_i,
  lbom_out_if.source            out_o
);

  cmd_t  cmd;
  stat_t stat;

  lbom_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.op),
    .stat_i     (stat),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd)
  );

  lbom_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .obj_x_i      (in_i.obj_x),
    .obj_y_i      (in_i.obj_y),
    .beam_index_i (in_i.beam_index),
    .beam_range_i (in_i.beam_range),
    .cmd_i        (cmd),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_index_o  (out_o.out_index),
    .out_range_o  (out_o.out_range),
    .masked_o     (out_o.masked),
    .stat_o       (stat)
  );

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.count <= CNT_W'(MAX_OBJECTS))
    else $error("object count beyond table size");

  a_beam_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.op == OP_BEAM) |=> !in_i.ready)
    else $error("new item taken while a beam is in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> (out_o.valid
      && $stable({out_o.out_index, out_o.out_range, out_o.masked})))
    else $error("result changed while the receiver stalls");
`endif

endmodule
